// ===== design/dlrs_pkg.sv =====
`timescale 1ns / 1ps
package dlrs_pkg;
  localparam int Capacity = 64;
  localparam int AddrW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam int ValW = 30;
  localparam int Buckets = 10;
  localparam int QDepth = 4;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            is_last;
  } in_item_t;

  typedef struct packed {
    logic [ValW-1:0] value_res;
    logic            is_last_res;
    logic            overflow;
  } out_item_t;

  // Entry handed from the front part to the back part.
  typedef struct packed {
    logic [ValW-1:0] value;
    logic            store;
    logic            last;
    logic            dropped;
  } q_item_t;
endpackage

// ===== design/dlrs_front.sv =====
`timescale 1ns / 1ps
// Counts arriving items, decides store or drop, and queues them for the back part.
module dlrs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_start,
  input  dlrs_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               in_busy,
  output logic               q_push,
  output dlrs_pkg::q_item_t  q_item
);
  logic [dlrs_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic                      drop_r, drop_nxt;
  logic                      accept, full_set;

  assign in_busy  = q_full;
  assign accept   = in_start && !q_full;
  assign full_set = (cnt_r == dlrs_pkg::CntW'(dlrs_pkg::Capacity));

  always_comb begin
    q_item.value   = in_data.value;
    q_item.store   = !full_set;
    q_item.last    = in_data.is_last;
    q_item.dropped = drop_r || full_set;
    q_push         = accept;
    cnt_nxt        = cnt_r;
    drop_nxt       = drop_r;
    if (accept) begin
      if (in_data.is_last) begin
        cnt_nxt  = '0;
        drop_nxt = 1'b0;
      end else if (full_set) begin
        drop_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      drop_r <= drop_nxt;
    end
  end
endmodule

// ===== design/dlrs_queue.sv =====
`timescale 1ns / 1ps
module dlrs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dlrs_pkg::q_item_t push_item,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output dlrs_pkg::q_item_t head
);
  localparam int PtrW = $clog2(dlrs_pkg::QDepth);
  dlrs_pkg::q_item_t          mem_r [dlrs_pkg::QDepth];
  logic [PtrW-1:0]            wp_r, rp_r;
  logic [PtrW:0]              n_r;

  assign full      = (n_r == (PtrW+1)'(dlrs_pkg::QDepth));
  assign not_empty = (n_r != '0);
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      n_r  <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      n_r <= n_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule

// ===== design/dlrs_back.sv =====
`timescale 1ns / 1ps
// Stores values, then per pass: count digits, prefix, scatter, copy back; then emit.
// Each stored value carries a running quotient so every pass needs only /10 by reciprocal.
module dlrs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [3:0]        passes,
  input  logic              q_valid,
  input  dlrs_pkg::q_item_t q_head,
  output logic              q_pop,
  output logic              idle,
  output logic              out_strobe,
  output dlrs_pkg::out_item_t out_data
);
  localparam int AW = dlrs_pkg::AddrW;
  localparam int CW = dlrs_pkg::CntW;
  localparam int VW = dlrs_pkg::ValW;
  localparam int EW = 2 * VW;

  typedef enum logic [2:0] {
    S_LOAD, S_COUNT, S_PREFIX, S_SCATTER, S_COPY, S_EMIT
  } state_t;

  // entry: original value and current quotient
  logic [EW-1:0] vmem [dlrs_pkg::Capacity];
  logic [EW-1:0] bmem [dlrs_pkg::Capacity];
  logic [CW-1:0] bcnt_r [dlrs_pkg::Buckets];

  state_t        st_r;
  logic [CW-1:0] n_r;
  logic [CW-1:0] idx_r;
  logic [3:0]    pass_r;
  logic [3:0]    bk_r;
  logic [CW-1:0] acc_r;
  logic          drop_r;
  logic          rd_v_r;
  logic [EW-1:0] rd_r;
  logic [EW-1:0] brd_r;
  logic [CW-1:0] ridx_r;

  logic [VW-1:0] quo, rq;
  logic [3:0]    dig;
  logic [VW+35-1:0] prod;

  // quotient by 10: multiply by ceil(2^35/10)
  always_comb begin
    rq   = rd_r[VW-1:0];
    prod = (VW+35)'(rq) * (VW+35)'(35'd3435973837);
    quo  = VW'(prod >> 35);
    dig  = 4'(rq - VW'(quo * VW'(10)));
  end

  assign q_pop = (st_r == S_LOAD) && q_valid;
  assign idle  = (st_r == S_LOAD) && !q_valid;

  always_ff @(posedge clk) begin
    rd_r  <= vmem[idx_r[AW-1:0]];
    brd_r <= bmem[idx_r[AW-1:0]];
    if (q_pop && q_head.store)
      vmem[n_r[AW-1:0]] <= {q_head.value, q_head.value};
    if (st_r == S_SCATTER && rd_v_r)
      bmem[bcnt_r[dig][AW-1:0]] <= {rd_r[EW-1:VW], quo};
    if (st_r == S_COPY && rd_v_r)
      vmem[ridx_r[AW-1:0]] <= brd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_LOAD;
      n_r        <= '0;
      idx_r      <= '0;
      pass_r     <= '0;
      bk_r       <= '0;
      acc_r      <= '0;
      drop_r     <= 1'b0;
      rd_v_r     <= 1'b0;
      ridx_r     <= '0;
      out_strobe <= 1'b0;
      for (int i = 0; i < dlrs_pkg::Buckets; i++) bcnt_r[i] <= '0;
    end else begin
      out_strobe <= 1'b0;
      rd_v_r     <= 1'b0;
      ridx_r     <= idx_r;
      case (st_r)
        S_LOAD: begin
          if (q_pop) begin
            drop_r <= q_head.dropped;
            if (q_head.store) n_r <= n_r + 1'b1;
            if (q_head.last) begin
              idx_r  <= '0;
              pass_r <= '0;
              for (int i = 0; i < dlrs_pkg::Buckets; i++) bcnt_r[i] <= '0;
              st_r <= (passes == 4'd0) ? S_EMIT : S_COUNT;
            end
          end
        end
        S_COUNT: begin
          if (idx_r < n_r) begin
            idx_r  <= idx_r + 1'b1;
            rd_v_r <= 1'b1;
          end
          if (rd_v_r) bcnt_r[dig] <= bcnt_r[dig] + 1'b1;
          if (idx_r >= n_r && !rd_v_r) begin
            st_r  <= S_PREFIX;
            bk_r  <= '0;
            acc_r <= '0;
          end
        end
        S_PREFIX: begin
          // turn counts into start offsets, one bucket a cycle
          bcnt_r[bk_r] <= acc_r;
          acc_r <= acc_r + bcnt_r[bk_r];
          bk_r  <= bk_r + 1'b1;
          if (bk_r == 4'(dlrs_pkg::Buckets - 1)) begin
            st_r  <= S_SCATTER;
            idx_r <= '0;
          end
        end
        S_SCATTER: begin
          if (idx_r < n_r) begin
            idx_r  <= idx_r + 1'b1;
            rd_v_r <= 1'b1;
          end
          if (rd_v_r) bcnt_r[dig] <= bcnt_r[dig] + 1'b1;
          if (idx_r >= n_r && !rd_v_r) begin
            st_r  <= S_COPY;
            idx_r <= '0;
          end
        end
        S_COPY: begin
          if (idx_r < n_r) begin
            idx_r  <= idx_r + 1'b1;
            rd_v_r <= 1'b1;
          end
          if (idx_r >= n_r && !rd_v_r) begin
            idx_r <= '0;
            for (int i = 0; i < dlrs_pkg::Buckets; i++) bcnt_r[i] <= '0;
            pass_r <= pass_r + 1'b1;
            st_r <= (pass_r + 1'b1 == passes) ? S_EMIT : S_COUNT;
          end
        end
        S_EMIT: begin
          if (idx_r < n_r) begin
            idx_r  <= idx_r + 1'b1;
            rd_v_r <= 1'b1;
          end
          if (rd_v_r) begin
            out_strobe           <= 1'b1;
            out_data.value_res   <= rd_r[EW-1:VW];
            out_data.is_last_res <= (ridx_r + 1'b1 == n_r);
            out_data.overflow    <= drop_r;
          end
          if (idx_r >= n_r && !rd_v_r) begin
            n_r    <= '0;
            idx_r  <= '0;
            drop_r <= 1'b0;
            st_r   <= S_LOAD;
          end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end
endmodule

// ===== design/decimal_lsd_radix_sorter.sv =====
`timescale 1ns / 1ps
// Items load at one per cycle into a 64-entry store while no sort runs; an item marked
// last starts the sort. Each digit pass walks the store three times (count, scatter,
// copy back) plus an offset setup over the ten buckets; results then emit on
// out_valid, one per cycle, which the receiver cannot stall.
// busy is high while the item queue is full; items keep queuing during a sort.
// cfg_ready is high only when the block is idle.
module decimal_lsd_radix_sorter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dlrs_pkg::in_item_t  in_data,
  output logic                out_valid,
  output dlrs_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_data
);
  logic              q_full, q_ne, q_push, q_pop, idle;
  dlrs_pkg::q_item_t q_in, q_head;
  logic [3:0]        passes_r;

  assign cfg_ready = idle;
  always_ff @(posedge clk) begin
    if (!rst_n) passes_r <= 4'd3;
    else if (cfg_valid && cfg_ready) passes_r <= cfg_data;
  end

  dlrs_front u_front (
    .clk(clk), .rst_n(rst_n), .in_start(start), .in_data(in_data),
    .q_full(q_full), .in_busy(busy), .q_push(q_push), .q_item(q_in)
  );

  dlrs_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_item(q_in), .pop(q_pop),
    .full(q_full), .not_empty(q_ne), .head(q_head)
  );

  dlrs_back u_back (
    .clk(clk), .rst_n(rst_n), .passes(passes_r), .q_valid(q_ne), .q_head(q_head),
    .q_pop(q_pop), .idle(idle), .out_strobe(out_valid), .out_data(out_data)
  );
endmodule

// ===== sim/tb_decimal_lsd_radix_sorter.sv =====
`timescale 1ns / 1ps
module tb_decimal_lsd_radix_sorter;
  localparam int WatchLimit = 20000;

  class sort_scoreboard;
    logic [dlrs_pkg::ValW-1:0] set_vals[$];
    logic                      set_dropped;
    logic [3:0]                passes;
    dlrs_pkg::out_item_t       sorted_q[$];
    int                        errors;

    function new();
      set_dropped = 1'b0;
      passes = 4'd3;
      errors = 0;
    endfunction

    function void note_item(dlrs_pkg::in_item_t it);
      logic [dlrs_pkg::ValW-1:0] vals[$];
      logic [dlrs_pkg::ValW-1:0] bkt[dlrs_pkg::Buckets][$];
      longint unsigned div;
      int d;
      dlrs_pkg::out_item_t r;
      if (set_vals.size() < dlrs_pkg::Capacity) set_vals = {set_vals, it.value};
      else set_dropped = 1'b1;
      if (!it.is_last) return;
      vals = set_vals;
      div = 1;
      for (int p = 0; p < passes; p++) begin
        for (int b = 0; b < dlrs_pkg::Buckets; b++) bkt[b].delete();
        foreach (vals[i]) begin
          d = int'((longint'(vals[i]) / div) % 10);
          bkt[d] = {bkt[d], vals[i]};
        end
        vals.delete();
        for (int b = 0; b < dlrs_pkg::Buckets; b++) foreach (bkt[b][j]) vals = {vals, bkt[b][j]};
        div = div * 10;
      end
      foreach (vals[i]) begin
        r.value_res = vals[i];
        r.is_last_res = (i == vals.size() - 1);
        r.overflow = set_dropped;
        sorted_q = {sorted_q, r};
      end
      set_vals.delete();
      set_dropped = 1'b0;
    endfunction

    task report_mismatch(string what, longint exp_v, longint got_v);
      $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
      errors++;
    endtask

    task check_result(dlrs_pkg::out_item_t got);
      dlrs_pkg::out_item_t exp_r;
      if (sorted_q.size() == 0) begin
        report_mismatch("result with nothing expected", 0, got.value_res);
        return;
      end
      exp_r = sorted_q.pop_front();
      if (got.value_res !== exp_r.value_res)
        report_mismatch("value_res", exp_r.value_res, got.value_res);
      if (got.is_last_res !== exp_r.is_last_res)
        report_mismatch("is_last_res", exp_r.is_last_res, got.is_last_res);
      if (got.overflow !== exp_r.overflow)
        report_mismatch("overflow", exp_r.overflow, got.overflow);
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  dlrs_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  dlrs_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [3:0]          cfg_data = 4'd0;

  sort_scoreboard sb = new();
  int idle_pct = 9;
  int idle_cycles = 0;

  decimal_lsd_radix_sorter DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
    if (rst_n && ((start && !busy) || out_valid || (cfg_valid && cfg_ready))) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Hold the item until accepted; idle beforehand at the current rate.
  // start stays high after acceptance so the next item can follow at once.
  task automatic send_item(logic [dlrs_pkg::ValW-1:0] v, logic last);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= '{value: v, is_last: last};
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(in_data);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.sorted_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_passes(logic [3:0] p);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= p;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.passes = p;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [dlrs_pkg::ValW-1:0] rand_value();
    case ($urandom_range(3))
      0: return dlrs_pkg::ValW'($urandom_range(99));
      1: return dlrs_pkg::ValW'($urandom_range(999999999));
      2: return dlrs_pkg::ValW'($urandom) ;
      default: return dlrs_pkg::ValW'($urandom_range(9999));
    endcase
  endfunction

  task automatic send_set(int n);
    for (int i = 0; i < n; i++) send_item(rand_value(), i == n - 1);
  endtask

  initial begin
    int sent;
    int phase;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Directed: extremes, single value, ties, overflow with a dropped last item.
    send_item(30'd0, 1'b1);
    send_item(30'd999999999, 1'b0);
    send_item(30'h3FFFFFFF, 1'b0);
    send_item(30'd0, 1'b0);
    send_item(30'd15, 1'b0);
    send_item(30'd5, 1'b0);
    send_item(30'd15, 1'b1);
    write_passes(4'd0);
    send_item(30'd7, 1'b0);
    send_item(30'd3, 1'b0);
    send_item(30'd9, 1'b1);
    write_passes(4'd15);
    send_item(30'h3FFFFFFF, 1'b0);
    send_item(30'd1000000000, 1'b0);
    send_item(30'd1, 1'b1);
    write_passes(4'd1);
    send_set(66);
    write_passes(4'd9);
    sent = 0;
    phase = 0;
    while (sent < 140) begin
      int n;
      if (phase == 0 && sent >= 45) begin
        write_passes(4'($urandom_range(15)));
        idle_pct = 62;
        phase = 1;
      end else if (phase == 1 && sent >= 95) begin
        write_passes(4'($urandom_range(2, 5)));
        idle_pct = 0;
        phase = 2;
      end
      n = ($urandom_range(15) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
      send_set(n);
      sent += n;
    end
    drain();
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== decimal_lsd_radix_sorter.f =====
design/dlrs_pkg.sv
design/dlrs_front.sv
design/dlrs_queue.sv
design/dlrs_back.sv
design/decimal_lsd_radix_sorter.sv
sim/tb_decimal_lsd_radix_sorter.sv
